[src/gtf_pkg.sv]
// Package for the grouped team FIFO: status codes, item kinds and control types.
// No dependencies.
`timescale 1ns / 1ps
package gtf_pkg;
  typedef enum logic [1:0] {
    KIND_DEFINE  = 2'd0,
    KIND_ENQUEUE = 2'd1,
    KIND_DEQUEUE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DEQ     = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  typedef struct packed {
    logic search;
    logic execute;
  } gtf_cmd_t;

  typedef struct packed {
    logic rd_wait;
  } gtf_stat_t;
endpackage

[src/grouped_team_fifo.sv]
// Top level of the grouped team FIFO: joins controller and datapath.
// Depends on gtf_pkg, gtf_ctrl, gtf_dp and gtf_ram.
`timescale 1ns / 1ps
// A transaction passes the registered membership search and the execute state before
// its strobe; a dequeue that returns an element waits for the registered read of
// the store RAM. One status result follows every transaction and is shown for one
// cycle with strobe_o; the receiver cannot stall it. The group store is not cleared.
module grouped_team_fifo import gtf_pkg::*; #(
  parameter int GROUPS      = 16,
  parameter int GROUP_DEPTH = 16,
  parameter int MEMBERS     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [15:0] element_i,
  input  logic [3:0]  group_id_i,
  output logic        strobe_o,
  output logic [2:0]  status_o,
  output logic [15:0] dequeued_o
);
  gtf_cmd_t  cmd;
  gtf_stat_t stat;

  gtf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .stat_i(stat), .cmd_o(cmd), .busy, .strobe_o
  );

  gtf_dp #(.Groups(GROUPS), .GroupDepth(GROUP_DEPTH), .Members(MEMBERS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .kind_i, .element_i, .group_id_i,
    .stat_o(stat), .status_o, .dequeued_o
  );
endmodule

[src/gtf_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gtf_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/gtf_ctrl.sv]
// Controller state machine of the grouped team FIFO.
// Depends on gtf_pkg.
`timescale 1ns / 1ps
module gtf_ctrl import gtf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  gtf_stat_t stat_i,
  output gtf_cmd_t  cmd_o,
  output logic      busy,
  output logic      strobe_o
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_READ  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   strobe_q, strobe_d;

  always_comb begin
    state_d  = state_q;
    strobe_d = 1'b0;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.search = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        if (stat_i.rd_wait) begin
          state_d = S_READ;
        end else begin
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_READ: begin
        strobe_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = strobe_q;

  a_exec_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |=> state_q == S_EXEC) else $error("look not followed by exec");
  a_strobe_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> state_q == S_IDLE) else $error("strobe while busy");
  a_read_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> strobe_q) else $error("read without result");
endmodule

[src/gtf_dp.sv]
// Datapath of the grouped team FIFO: membership table, group stores and order ring.
// Depends on gtf_pkg and gtf_ram.
`timescale 1ns / 1ps
module gtf_dp import gtf_pkg::*; #(
  parameter int Groups     = 16,
  parameter int GroupDepth = 16,
  parameter int Members    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gtf_cmd_t    cmd_i,
  input  logic [1:0]  kind_i,
  input  logic [15:0] element_i,
  input  logic [3:0]  group_id_i,
  output gtf_stat_t   stat_o,
  output logic [2:0]  status_o,
  output logic [15:0] dequeued_o
);
  localparam int GW = $clog2(Groups);
  localparam int DW = $clog2(GroupDepth);
  localparam int MW = $clog2(Members);
  localparam int SW = GW + DW;

  logic [Members-1:0] valid_q;
  logic [15:0]        mval_q [Members];
  logic [GW-1:0]      mgrp_q [Members];
  logic [DW-1:0]      ghead_q [Groups];
  logic [DW-1:0]      gtail_q [Groups];
  logic [DW:0]        gcnt_q  [Groups];
  logic [GW-1:0]      ring_q  [Groups];
  logic [GW-1:0]      ohead_q;
  logic [GW:0]        ocnt_q;

  logic [1:0]  kind_q;
  logic [15:0] elem_q;
  logic [3:0]  gid_q;
  logic        hit_q, free_ok_q;
  logic [MW-1:0] hit_idx_q, free_idx_q;
  logic [GW-1:0] hit_grp_q;
  logic [2:0]  status_q;
  logic [15:0] deq_q;
  logic        deq_pend_q;

  logic          hit_d, free_ok_d;
  logic [MW-1:0] hit_idx_d, free_idx_d;
  logic [GW-1:0] hit_grp_d;

  always_comb begin
    hit_d = 1'b0;
    hit_idx_d = '0;
    hit_grp_d = '0;
    free_ok_d = 1'b0;
    free_idx_d = '0;
    for (int i = Members - 1; i >= 0; i--) begin
      if (valid_q[i] && mval_q[i] == element_i) begin
        hit_d = 1'b1;
        hit_idx_d = MW'(i);
        hit_grp_d = mgrp_q[i];
      end
      if (!valid_q[i]) begin
        free_ok_d = 1'b1;
        free_idx_d = MW'(i);
      end
    end
  end

  logic [GW-1:0] eg, dg;
  logic          gid_ok;
  logic [GW:0]   ring_sum;
  logic [GW-1:0] tail_pos;
  assign eg       = hit_grp_q;
  assign dg       = ring_q[ohead_q];
  assign gid_ok   = ({28'd0, gid_q} < 32'(Groups));
  assign ring_sum = {1'b0, ohead_q} + ocnt_q;
  assign tail_pos = GW'(ring_sum >= (GW + 1)'(Groups) ? ring_sum - (GW + 1)'(Groups)
                                                      : ring_sum);

  logic          we;
  logic [SW-1:0] waddr, raddr;
  logic [15:0]   rdata;
  logic          do_enq, do_deq;

  always_comb begin
    do_enq = 1'b0;
    do_deq = 1'b0;
    if (cmd_i.execute) begin
      if (kind_q == KIND_ENQUEUE && hit_q && gcnt_q[eg] < (DW + 1)'(GroupDepth)
          && !(gcnt_q[eg] == '0 && ocnt_q >= (GW + 1)'(Groups))) begin
        do_enq = 1'b1;
      end
      if (kind_q == KIND_DEQUEUE && ocnt_q != '0 && gcnt_q[dg] != '0) begin
        do_deq = 1'b1;
      end
    end
  end

  assign we    = do_enq;
  assign waddr = {eg, gtail_q[eg]};
  assign raddr = {dg, ghead_q[dg]};
  assign stat_o.rd_wait = do_deq;

  gtf_ram #(.Width(16), .Depth(2 ** SW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(elem_q), .raddr_i(raddr), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      kind_q <= kind_i;
      elem_q <= element_i;
      gid_q  <= group_id_i;
      hit_q  <= hit_d;
      hit_idx_q <= hit_idx_d;
      hit_grp_q <= hit_grp_d;
      free_ok_q <= free_ok_d;
      free_idx_q <= free_idx_d;
    end
    if (cmd_i.execute && kind_q == KIND_DEFINE && gid_ok) begin
      if (hit_q) begin
        mgrp_q[hit_idx_q] <= GW'(gid_q);
      end else if (free_ok_q) begin
        mval_q[free_idx_q] <= elem_q;
        mgrp_q[free_idx_q] <= GW'(gid_q);
      end
    end
    if (do_enq && gcnt_q[eg] == '0) begin
      ring_q[tail_pos] <= eg;
    end
    if (deq_pend_q) begin
      deq_q <= rdata;
    end else if (cmd_i.execute) begin
      deq_q <= '0;
    end
    if (cmd_i.execute) begin
      case (kind_q)
        KIND_DEFINE:  status_q <= (gid_ok && (hit_q || free_ok_q)) ? ST_OK : ST_FULL;
        KIND_ENQUEUE: status_q <= !hit_q ? ST_UNKNOWN : (do_enq ? ST_OK : ST_FULL);
        KIND_DEQUEUE: status_q <= do_deq ? ST_DEQ : ST_EMPTY;
        default:      status_q <= ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      ohead_q    <= '0;
      ocnt_q     <= '0;
      deq_pend_q <= 1'b0;
      for (int g = 0; g < Groups; g++) begin
        ghead_q[g] <= '0;
        gtail_q[g] <= '0;
        gcnt_q[g]  <= '0;
      end
    end else begin
      deq_pend_q <= do_deq;
      if (cmd_i.execute && kind_q == KIND_DEFINE && gid_ok && !hit_q && free_ok_q) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (do_enq) begin
        gtail_q[eg] <= DW'((DW + 1)'(gtail_q[eg]) + 1'b1 == (DW + 1)'(GroupDepth)
                       ? '0 : gtail_q[eg] + 1'b1);
        gcnt_q[eg]  <= gcnt_q[eg] + 1'b1;
        if (gcnt_q[eg] == '0) begin
          ocnt_q <= ocnt_q + 1'b1;
        end
      end
      if (do_deq) begin
        ghead_q[dg] <= DW'((DW + 1)'(ghead_q[dg]) + 1'b1 == (DW + 1)'(GroupDepth)
                       ? '0 : ghead_q[dg] + 1'b1);
        gcnt_q[dg]  <= gcnt_q[dg] - 1'b1;
        if (gcnt_q[dg] == (DW + 1)'(1)) begin
          ohead_q <= GW'((GW + 1)'(ohead_q) + 1'b1 == (GW + 1)'(Groups)
                     ? '0 : ohead_q + 1'b1);
          ocnt_q  <= ocnt_q - 1'b1;
        end
      end
    end
  end

  assign status_o   = status_q;
  assign dequeued_o = deq_pend_q ? rdata : deq_q;

  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= (GW + 1)'(Groups)) else $error("order ring overflow");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_enq && do_deq)) else $error("enqueue and dequeue together");
  a_deq_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_deq |-> ocnt_q != '0) else $error("dequeue from empty ring");
endmodule

[verif/tb_top.sv]
// Self-checking testbench for the grouped team FIFO: a directed part, then random traffic.
// Depends on gtf_pkg and grouped_team_fifo; predicts every status result and checks it.
`timescale 1ns / 1ps
module tb_top;
  import gtf_pkg::*;

  localparam int NGRP  = 16;
  localparam int GDEP  = 16;
  localparam int NMEM  = 64;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] element;
    logic [3:0]  group_id;
    logic [3:0]  gap;
    logic        drain;
  } txn_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] value;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = '0;
  logic [15:0] element_i = '0;
  logic [3:0]  group_id_i = '0;
  logic        strobe_o;
  logic [2:0]  status_o;
  logic [15:0] dequeued_o;

  grouped_team_fifo dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .kind_i(kind_i), .element_i(element_i), .group_id_i(group_id_i),
    .strobe_o(strobe_o), .status_o(status_o), .dequeued_o(dequeued_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state.
  logic [15:0] tbl_value [NMEM];
  logic [3:0]  tbl_group [NMEM];
  logic        tbl_valid [NMEM];
  logic [15:0] grp_queue [NGRP][$];
  logic [3:0]  grp_order [$];

  txn_t    pending_q [$];
  status_t status_q [$];
  int      mismatches = 0;
  int      cycles = 0;
  int      n_sent = 0;
  int      n_deq = 0;
  int      n_full = 0;
  int      n_unknown = 0;
  bit      stim_done = 0;

  function automatic int find_member(logic [15:0] v);
    for (int i = 0; i < NMEM; i++) begin
      if (tbl_valid[i] && tbl_value[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic status_t predict_status(txn_t t);
    status_t r;
    int idx;
    logic [3:0] g;
    r = '{status: ST_OK, value: 16'd0};
    case (kind_e'(t.kind))
      KIND_DEFINE: begin
        idx = find_member(t.element);
        if (idx < 0) begin
          for (int i = 0; i < NMEM; i++) begin
            if (!tbl_valid[i]) begin
              idx = i;
              break;
            end
          end
          if (idx < 0) begin
            r.status = ST_FULL;
            return r;
          end
          tbl_valid[idx] = 1'b1;
          tbl_value[idx] = t.element;
        end
        tbl_group[idx] = t.group_id;
      end
      KIND_ENQUEUE: begin
        idx = find_member(t.element);
        if (idx < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          g = tbl_group[idx];
          if (grp_queue[g].size() >= GDEP) begin
            r.status = ST_FULL;
          end else begin
            if (grp_queue[g].size() == 0) grp_order.push_back(g);
            grp_queue[g].push_back(t.element);
          end
        end
      end
      KIND_DEQUEUE: begin
        if (grp_order.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          g = grp_order[0];
          r.status = ST_DEQ;
          r.value = grp_queue[g].pop_front();
          if (grp_queue[g].size() == 0) void'(grp_order.pop_front());
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic txn_t make_txn(logic [1:0] k, logic [15:0] e, logic [3:0] g);
    txn_t t;
    t.kind = k;
    t.element = e;
    t.group_id = g;
    t.gap = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 13));
    t.drain = 1'b0;
    return t;
  endfunction

  // Driver: idles for the drawn gap, optionally waits for every result to come back.
  txn_t cur;
  int   wait_left = 0;
  bit   have_cur = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        status_q.push_back(predict_status(cur));
        n_sent++;
        have_cur = 0;
        start <= 1'b0;
      end else if (!start) begin
        if (!have_cur && pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          wait_left = cur.gap;
          have_cur = 1;
        end
        if (have_cur) begin
          if (wait_left > 0) begin
            wait_left--;
          end else if (!cur.drain || status_q.size() == 0) begin
            start <= 1'b1;
            kind_i <= cur.kind;
            element_i <= cur.element;
            group_id_i <= cur.group_id;
          end
        end
      end
    end
  end

  // Monitor.
  status_t want;
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: status %0d value %h", status_o, dequeued_o);
      end else begin
        want = status_q.pop_front();
        if (want.status == ST_DEQ) n_deq++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_UNKNOWN) n_unknown++;
        if (status_o !== want.status || dequeued_o !== want.value) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: status exp %0d got %0d, dequeued exp %h got %h",
                     want.status, status_o, want.value, dequeued_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  logic [15:0] pool [24];
  txn_t t;
  int   r;
  initial begin
    for (int i = 0; i < NMEM; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < 24; i++) pool[i] = 16'($urandom);
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;

    // Directed part.
    pending_q.push_back(make_txn(KIND_DEQUEUE, 16'h0, 4'h0));
    pending_q.push_back(make_txn(KIND_ENQUEUE, 16'h1234, 4'h0));
    pending_q.push_back(make_txn(KIND_DEFINE, 16'h0000, 4'h0));
    pending_q.push_back(make_txn(KIND_DEFINE, 16'hFFFF, 4'hF));
    pending_q.push_back(make_txn(KIND_DEFINE, 16'h5A5A, 4'h0));
    pending_q.push_back(make_txn(KIND_ENQUEUE, 16'hFFFF, 4'h0));
    pending_q.push_back(make_txn(KIND_ENQUEUE, 16'h0000, 4'h0));
    pending_q.push_back(make_txn(KIND_ENQUEUE, 16'hFFFF, 4'h0));
    pending_q.push_back(make_txn(KIND_ENQUEUE, 16'h5A5A, 4'h0));
    pending_q.push_back(make_txn(KIND_DEFINE, 16'hFFFF, 4'h3));
    pending_q.push_back(make_txn(KIND_ENQUEUE, 16'hFFFF, 4'h0));
    pending_q.push_back(make_txn(KIND_NONE, 16'hFFFF, 4'hF));
    for (int i = 0; i < 6; i++) pending_q.push_back(make_txn(KIND_DEQUEUE, 16'h0, 4'h0));
    // Fill group zero past its depth, then drain it again.
    for (int i = 0; i < GDEP + 1; i++) pending_q.push_back(make_txn(KIND_ENQUEUE, 16'h0000, 4'h0));
    t = make_txn(KIND_DEQUEUE, 16'h0, 4'h0);
    t.drain = 1'b1;
    pending_q.push_back(t);
    for (int i = 0; i < GDEP; i++) pending_q.push_back(make_txn(KIND_DEQUEUE, 16'h0, 4'h0));

    // Random part: mostly enqueue/dequeue of defined values, some noise.
    for (int n = 0; n < 1650; n++) begin
      r = $urandom_range(0, 99);
      if (n == 1200) begin
        // Fill the membership table with fresh values to reach its limit.
        for (int i = 0; i < NMEM + 2; i++)
          pending_q.push_back(make_txn(KIND_DEFINE, 16'($urandom), 4'($urandom)));
      end
      if (r < 10)
        t = make_txn(KIND_DEFINE, pool[$urandom_range(0, 23)], 4'($urandom));
      else if (r < 55)
        t = make_txn(KIND_ENQUEUE, pool[$urandom_range(0, 23)], 4'h0);
      else if (r < 60)
        t = make_txn(KIND_ENQUEUE, 16'($urandom), 4'($urandom));
      else if (r < 97)
        t = make_txn(KIND_DEQUEUE, 16'($urandom), 4'($urandom));
      else
        t = make_txn(KIND_NONE, 16'($urandom), 4'($urandom));
      if ($urandom_range(0, 199) == 0) t.drain = 1'b1;
      pending_q.push_back(t);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !have_cur && !start);
    wait (status_q.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d transactions: %0d dequeues returned data, %0d full, %0d unknown.",
             n_sent, n_deq, n_full, n_unknown);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[filelist.f]
src/gtf_pkg.sv
src/gtf_ram.sv
src/gtf_ctrl.sv
src/gtf_dp.sv
src/grouped_team_fifo.sv
verif/tb_top.sv
